// ===== rtl/upd_pkg.sv =====
// ----------------------------------------------------------------------------
// upd_pkg: shared types and constants of the URL percent decoder
// Character codes, decode phase, the command passed from front to back end,
// and the hex digit classifier.
// ----------------------------------------------------------------------------
package upd_pkg;

  // Character codes
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  // Offset that maps the low nibble of 'a'..'f' / 'A'..'F' to 10..15
  localparam logic [3:0] HEX_ALPHA_OFS = 4'd9;

  // Default depth of the command queue
  localparam int CMD_DEPTH = 4;

  // Most bytes one item can yield
  localparam int MAX_BYTES = 3;

  // Decode phase
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PCT   = 2'd1,
    PH_DIGIT = 2'd2
  } upd_phase_t;

  // One command: up to three bytes, how many are used, and the end mark
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [1:0]                count;
    logic                      last;
  } upd_cmd_t;

  // Hex digit classification
  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } upd_nibble_t;

  function automatic upd_nibble_t hex_nibble(logic [7:0] c);
    upd_nibble_t r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.ok  = 1'b1;
      r.val = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r.ok  = 1'b1;
      r.val = c[3:0] + HEX_ALPHA_OFS;
    end
    return r;
  endfunction

endpackage

// ===== rtl/upd_front.sv =====
// ----------------------------------------------------------------------------
// upd_front: input side of the URL percent decoder
// Accepts one character per cycle while accept is high, tracks the escape
// phase and turns each item into a command of zero to three output bytes.
// ----------------------------------------------------------------------------
module upd_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [7:0]       in_byte,
  input  logic             in_last,
  output logic             cmd_push,
  output upd_pkg::upd_cmd_t cmd
);
  import upd_pkg::*;

  upd_phase_t  phase, phase_next;
  logic [7:0]  held_digit, held_digit_next;

  upd_nibble_t nib_in, nib_held;
  logic        idle_emit;
  logic [7:0]  idle_byte;
  logic        idle_pct;

  // Phase and held digit registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      held_digit <= '0;
    end else if (accept) begin
      phase      <= phase_next;
      held_digit <= held_digit_next;
    end
  end

  // Decode of the current byte as if from idle
  always_comb begin
    idle_emit = 1'b1;
    idle_byte = in_byte;
    idle_pct  = 1'b0;
    if (in_byte == CH_PLUS) begin
      idle_byte = CH_SPACE;
    end else if (in_byte == CH_PERCENT) begin
      idle_emit = in_last;
      idle_pct  = !in_last;
    end
  end

  // Next phase and command
  always_comb begin
    nib_in          = hex_nibble(in_byte);
    nib_held        = hex_nibble(held_digit);
    phase_next      = idle_pct ? PH_PCT : PH_IDLE;
    held_digit_next = '0;
    cmd             = '0;
    cmd.last        = in_last;
    unique case (phase)
      PH_PCT: begin
        if (nib_in.ok && !in_last) begin
          phase_next      = PH_DIGIT;
          held_digit_next = in_byte;
        end else begin
          // bad or truncated escape: literal '%', then the byte from idle
          cmd.bytes[0] = CH_PERCENT;
          cmd.bytes[1] = idle_byte;
          cmd.count    = 2'd1 + {1'b0, idle_emit};
        end
      end
      PH_DIGIT: begin
        if (nib_in.ok && nib_held.ok) begin
          cmd.bytes[0] = {nib_held.val, nib_in.val};
          cmd.count    = 2'd1;
          phase_next   = PH_IDLE;
        end else begin
          // literal '%' and held digit, then the byte from idle
          cmd.bytes[0] = CH_PERCENT;
          cmd.bytes[1] = held_digit;
          cmd.bytes[2] = idle_byte;
          cmd.count    = 2'd2 + {1'b0, idle_emit};
        end
      end
      default: begin
        cmd.bytes[0] = idle_byte;
        cmd.count    = {1'b0, idle_emit};
      end
    endcase
    // end of string always returns to idle
    if (in_last) begin
      phase_next      = PH_IDLE;
      held_digit_next = '0;
    end
  end

  // Only commands that carry bytes enter the queue
  assign cmd_push = accept && (cmd.count != 2'd0);

endmodule

// ===== rtl/upd_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// upd_cmd_fifo: command queue between front and back end
// Small register FIFO; the head entry is presented while not empty.
// ----------------------------------------------------------------------------
module upd_cmd_fifo #(
  parameter int DEPTH = upd_pkg::CMD_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  upd_pkg::upd_cmd_t wr_cmd,
  input  logic              pop,
  output upd_pkg::upd_cmd_t head,
  output logic              full,
  output logic              empty
);
  import upd_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  upd_cmd_t        entries [DEPTH];
  logic [AW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   cnt;
  logic            do_push, do_pop;

  assign full    = (cnt == CW'(DEPTH));
  assign empty   = (cnt == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wr_cmd;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/upd_back.sv =====
// ----------------------------------------------------------------------------
// upd_back: output side of the URL percent decoder
// Steps the bytes of the head command into the output register, one per
// cycle while it is free or popped, and marks the final byte of a string.
// ----------------------------------------------------------------------------
module upd_back (
  input  logic              clk,
  input  logic              rst,
  input  upd_pkg::upd_cmd_t head,
  input  logic              head_valid,
  output logic              head_pop,
  input  logic              pop,
  output logic              empty,
  output logic [7:0]        out_byte,
  output logic              out_last
);
  import upd_pkg::*;

  logic       out_valid;
  logic [1:0] idx;
  logic       load;
  logic       at_end;

  assign load     = head_valid && (!out_valid || pop);
  assign at_end   = (idx == head.count - 2'd1);
  assign head_pop = load && at_end;
  assign empty    = !out_valid;

  // Byte index within the head command
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (load) begin
      idx <= at_end ? 2'd0 : idx + 2'd1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= head.bytes[idx];
      out_last <= head.last && at_end;
    end
  end

endmodule

// ===== rtl/url_percent_decoder.sv =====
// ----------------------------------------------------------------------------
// url_percent_decoder: streaming form-urlencoded text decoder
// Turns '+' into a space and %XX escapes into bytes; bad or truncated
// escapes pass through literally.
// ----------------------------------------------------------------------------
// Usage: the decoder takes one character per cycle on push while full is low
// and delivers decoded bytes from its output register, one per cycle while
// the consumer pops. An item yields 0 to 3 bytes; the command queue of
// CMD_DEPTH entries between the front and back ends soaks up the extra
// bytes of bad escapes, and full rises only when it is filled. An item that
// yields one byte keeps the full rate of one item per cycle while the
// consumer pops every cycle. A result passes through the command queue and
// then the output register: the command is queued when its item is accepted,
// and the output register loads it from the queue head once it is free.
// out_last marks the final byte of each string.
module url_percent_decoder #(
  parameter int CMD_DEPTH = upd_pkg::CMD_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       out_last
);
  import upd_pkg::*;

  upd_cmd_t cmd, head;
  logic     accept;
  logic     cmd_push, cmd_pop, cmd_full, cmd_empty;

  assign full   = cmd_full;
  assign accept = push && !cmd_full;

  upd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .cmd_push (cmd_push),
    .cmd      (cmd)
  );

  upd_cmd_fifo #(
    .DEPTH (CMD_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (cmd_push),
    .wr_cmd (cmd),
    .pop    (cmd_pop),
    .head   (head),
    .full   (cmd_full),
    .empty  (cmd_empty)
  );

  upd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (!cmd_empty),
    .head_pop   (cmd_pop),
    .pop        (pop),
    .empty      (empty),
    .out_byte   (out_byte),
    .out_last   (out_last)
  );

  // Queue is never written while full
  assert property (@(posedge clk) disable iff (rst) cmd_push |-> !cmd_full)
    else $error("command pushed into full queue");

  // End of string always produces a command
  assert property (@(posedge clk) disable iff (rst) (accept && in_last) |-> cmd_push)
    else $error("string end produced no output");

  // Back end only retires a command that is present
  assert property (@(posedge clk) disable iff (rst) cmd_pop |-> !cmd_empty)
    else $error("command popped from empty queue");

  // A pushed command carries at least one byte
  assert property (@(posedge clk) disable iff (rst) cmd_push |-> (cmd.count != 2'd0))
    else $error("empty command queued");

endmodule
